// ----- hw/rtl/spq_pkg.sv -----
`default_nettype none

package spq_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   localparam logic [1:0] STATUS_INSERTED = 2'd0;
   localparam logic [1:0] STATUS_POPPED   = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_EMPTY    = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  priority_req;
      logic [15:0] tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_priority;
      logic [15:0] out_tag;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] tag;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type newcomer;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
`default_nettype none

module spq_cell (
   input  wire                  clock,
   input  wire spq_pkg::ctrl_type  ctrl,
   input  wire                  occupied,
   input  wire                  left_lower,
   input  wire spq_pkg::entry_type left_entry,
   input  wire spq_pkg::entry_type right_entry,
   output logic                 lower,
   output spq_pkg::entry_type   entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // empty slots count as lower than anything, so the newcomer or a shifted entry can land there
   assign lower = !occupied || (entry_ff.prio < ctrl.newcomer.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && lower) begin
         if (left_lower) begin
            entry_in = left_entry;
         end else begin
            entry_in = ctrl.newcomer;
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue.sv -----
// A result appears in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle; every cell compares against the newcomer and
// shifts toward its neighbor in the same cycle. Requests stall only while a result
// waits in the output register for rsp_ready.
// Reset: synchronous, active high; clears the occupancy count and the output valid.
// Entry storage is not cleared; slots above the occupancy never reach a response.
`default_nettype none

module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire spq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output spq_pkg::rsp_type  rsp_data
);

   localparam int CountW = $clog2(QUEUE_DEPTH + 1);

   logic [CountW-1:0] count_ff;
   logic [CountW-1:0] count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   spq_pkg::rsp_type  rsp_data_ff;
   spq_pkg::rsp_type  rsp_data_in;

   logic              accept;
   logic              full;
   logic              empty;
   spq_pkg::ctrl_type ctrl;

   logic               [QUEUE_DEPTH-1:0] occupied;
   logic               [QUEUE_DEPTH-1:0] lower;
   spq_pkg::entry_type [QUEUE_DEPTH-1:0] entries;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CountW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      ctrl.insert        = accept && (req_data.opcode == spq_pkg::OP_INSERT) && !full;
      ctrl.pop           = accept && (req_data.opcode == spq_pkg::OP_POP) && !empty;
      ctrl.newcomer.prio = req_data.priority_req;
      ctrl.newcomer.tag  = req_data.tag;
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign occupied[i] = (count_ff > CountW'(i));
      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied[i]),
         .left_lower  ((i == 0) ? 1'b0 : lower[(i == 0) ? 0 : i - 1]),
         .left_entry  (entries[(i == 0) ? 0 : i - 1]),
         .right_entry (entries[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
         .lower       (lower[i]),
         .entry       (entries[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         if (req_data.opcode == spq_pkg::OP_INSERT) begin
            rsp_data_in.status = full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_INSERTED;
         end else if (empty) begin
            rsp_data_in.status = spq_pkg::STATUS_EMPTY;
         end else begin
            rsp_data_in.status       = spq_pkg::STATUS_POPPED;
            rsp_data_in.out_priority = entries[0].prio;
            rsp_data_in.out_tag      = entries[0].tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(QUEUE_DEPTH))
      else $error("occupancy above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow occupancy");

   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> (rsp_valid && rsp_data.status == spq_pkg::STATUS_POPPED
                    && rsp_data.out_priority == $past(entries[0].prio)))
      else $error("pop did not return head");
`endif

endmodule

`default_nettype wire
